FILE: hw/rtl/sapb_pkg.sv
// shared types and constants for the sweep and prune broadphase
package sapb_pkg;
  localparam int MaxObjectsDefault = 64;
  localparam int BoundW = 26;
  localparam logic signed [BoundW-1:0] BoundMax = 26'sh1FFFFFF;
  localparam logic signed [BoundW-1:0] BoundMin = -26'sh2000000;
  localparam int MaxPairsReset = 63;
  localparam logic [0:0] RegMaxPairs = 1'b0;

  typedef logic signed [BoundW-1:0] bound_t;

  // stored bounds of one object, x maximum lowest
  typedef struct packed {
    bound_t zmax;
    bound_t zmin;
    bound_t ymax;
    bound_t ymin;
    bound_t xmax;
  } box_t;

  // saturate a wide signed value into the bound range
  function automatic bound_t sat26(input logic signed [27:0] v);
    if (v > 28'(BoundMax)) begin
      return BoundMax;
    end else if (v < 28'(BoundMin)) begin
      return BoundMin;
    end else begin
      return v[BoundW-1:0];
    end
  endfunction
endpackage

FILE: hw/rtl/sapb_if.sv
// valid/ready channel interfaces for objects and results
interface sapb_obj_if;
  logic        valid;
  logic        ready;
  logic        is_sphere;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] pos_z;
  logic [22:0] half_x;
  logic [22:0] half_y;
  logic [22:0] half_z;
  logic [47:0] axis_row0;
  logic [47:0] axis_row1;
  logic [47:0] axis_row2;
  logic        last_object;
  modport source (output valid, is_sphere, pos_x, pos_y, pos_z, half_x, half_y, half_z,
    axis_row0, axis_row1, axis_row2, last_object, input ready);
  modport sink (input valid, is_sphere, pos_x, pos_y, pos_z, half_x, half_y, half_z,
    axis_row0, axis_row1, axis_row2, last_object, output ready);
endinterface

interface sapb_res_if;
  logic       valid;
  logic       ready;
  logic       pair_valid;
  logic [5:0] index_a;
  logic [5:0] index_b;
  logic [5:0] pair_count;
  logic       last;
  modport source (output valid, pair_valid, index_a, index_b, pair_count, last, input ready);
  modport sink (input valid, pair_valid, index_a, index_b, pair_count, last, output ready);
endinterface

FILE: hw/rtl/sapb_extent.sv
// iterative extent unit: one multiply-accumulate per cycle, nine steps
module sapb_extent (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        is_sphere,
  input  logic [22:0] half_x,
  input  logic [22:0] half_y,
  input  logic [22:0] half_z,
  input  logic [47:0] axis_row0,
  input  logic [47:0] axis_row1,
  input  logic [47:0] axis_row2,
  output logic        done,
  output logic [26:0] ext_x,
  output logic [26:0] ext_y,
  output logic [26:0] ext_z
);
  logic        busy;
  logic [40:0] acc;
  logic [1:0]  r;
  logic [1:0]  k;
  logic [47:0] row;
  logic [15:0] c;
  logic [16:0] mag;
  logic [22:0] h;
  logic [39:0] prod;
  logic [40:0] acc_sum;

  always_comb begin
    unique case (r)
      2'd0:    begin row = axis_row0; h = half_x; end
      2'd1:    begin row = axis_row1; h = half_y; end
      default: begin row = axis_row2; h = half_z; end
    endcase
    c = row[16*k +: 16];
    mag = c[15] ? (17'h10000 - {1'b0, c}) : {1'b0, c};
    prod = 40'(mag) * 40'(h);
    acc_sum = acc + 41'(prod);
  end

  // r walks the rows, k the world axes
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      r <= '0;
      k <= '0;
    end else if (start) begin
      busy <= 1'b1;
      r <= '0;
      k <= '0;
      acc <= '0;
    end else if (busy) begin
      if (is_sphere) begin
        ext_x <= 27'(half_x);
        ext_y <= 27'(half_x);
        ext_z <= 27'(half_x);
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        if (r == 2'd2) begin
          unique case (k)
            2'd0:    ext_x <= 27'(acc_sum >> 14);
            2'd1:    ext_y <= 27'(acc_sum >> 14);
            default: ext_z <= 27'(acc_sum >> 14);
          endcase
          acc <= '0;
          r <= '0;
          k <= k + 2'd1;
          if (k == 2'd2) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          acc <= acc_sum;
          r <= r + 2'd1;
        end
      end
    end
  end
endmodule

FILE: hw/rtl/sweep_and_prune_broadphase_unit.sv
// top level: object loading, insertion sort and x sweep
// usage:
//   obj channel takes one object per beat in index order; last_object closes
//   the frame. res channel returns the pair beats then one summary beat
//   (pair_valid 0, last 1, pair_count). the apb port writes max_pairs at
//   address 0 (reset 63); the user writes only while idle, the block has no check.
// object flow:
//   an oriented box holds obj.ready low through nine passes of the shared
//   multiply-accumulate extent unit, then six passes of the shared bound adder,
//   so no new object is taken until it is stored; a sphere skips the
//   multiply-accumulate passes. the final object adds a gather, the insertion
//   sort and the sweep, all through one read port per store.
// reset:
//   synchronous rst clears the counts and sets max_pairs to 63; the kept order
//   is rebuilt as identity on the first frame since previous_count starts at
//   zero, and unwritten entries are never read, so no clearing pass is needed.
// stall:
//   when res.ready is low the sweep holds on its pending beat; obj.ready stays
//   low until the frame summary has been taken.
module sweep_and_prune_broadphase_unit #(
  parameter int MAX_OBJECTS = sapb_pkg::MaxObjectsDefault
) (
  input  logic        clk,
  input  logic        rst,
  sapb_obj_if.sink    obj,
  sapb_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int IW = $clog2(MAX_OBJECTS);
  localparam int CW = $clog2(MAX_OBJECTS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_EXT, S_WB, S_INIT, S_GATHER, S_GREAD, S_GPUT, S_SORT, S_SREAD,
    S_SCMP, S_SWA, S_SWABOX, S_SWB, S_SWBCHK, S_SWBTEST, S_EMIT, S_SUM
  } state_t;

  state_t state;
  logic [5:0] max_pairs;
  logic [CW-1:0] load_count, previous_count, n;
  // per-object storage, one read port each
  sapb_pkg::bound_t object_xmin [MAX_OBJECTS];
  sapb_pkg::box_t   box_bounds  [MAX_OBJECTS];
  logic [IW-1:0]    sweep_order [MAX_OBJECTS];
  sapb_pkg::bound_t sweep_xmin  [MAX_OBJECTS];

  // captured input
  logic        in_sph, in_last, in_keep;
  logic signed [23:0] px, py, pz;
  logic [22:0] hx, hy, hz;
  logic [47:0] r0, r1, r2;
  logic        ext_start, ext_done;
  logic [26:0] ex, ey, ez;
  logic [2:0]  wb;
  logic [IW-1:0] slot;
  sapb_pkg::bound_t wxmax, wymin, wymax, wzmin;

  // gather, sort and sweep
  logic [CW-1:0] i, j, a, b;
  logic          reinit;
  logic [IW-1:0] gord, ko, prev_o, oa, ob;
  sapb_pkg::bound_t gx, kx, prev_x, bx;
  sapb_pkg::box_t abox, bbox;
  logic [6:0] pairs;

  sapb_extent u_ext (
    .clk, .rst, .start(ext_start), .is_sphere(in_sph),
    .half_x(hx), .half_y(hy), .half_z(hz),
    .axis_row0(r0), .axis_row1(r1), .axis_row2(r2),
    .done(ext_done), .ext_x(ex), .ext_y(ey), .ext_z(ez)
  );

  assign pready = 1'b1;
  assign prdata = {26'd0, max_pairs};
  assign obj.ready = (state == S_IDLE) && !rst;

  // shared bound adder, one bound per cycle
  logic signed [27:0] bsel_pos, bsel_ext;
  logic               bsel_sub;
  sapb_pkg::bound_t   wb_val;
  always_comb begin
    unique case (wb)
      3'd0:    begin bsel_pos = 28'(px); bsel_ext = 28'(ex); bsel_sub = 1'b1; end
      3'd1:    begin bsel_pos = 28'(px); bsel_ext = 28'(ex); bsel_sub = 1'b0; end
      3'd2:    begin bsel_pos = 28'(py); bsel_ext = 28'(ey); bsel_sub = 1'b1; end
      3'd3:    begin bsel_pos = 28'(py); bsel_ext = 28'(ey); bsel_sub = 1'b0; end
      3'd4:    begin bsel_pos = 28'(pz); bsel_ext = 28'(ez); bsel_sub = 1'b1; end
      default: begin bsel_pos = 28'(pz); bsel_ext = 28'(ez); bsel_sub = 1'b0; end
    endcase
    wb_val = sapb_pkg::sat26(bsel_sub ? bsel_pos - bsel_ext : bsel_pos + bsel_ext);
  end

  always_ff @(posedge clk) begin
    ext_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      max_pairs <= 6'(sapb_pkg::MaxPairsReset);
      load_count <= '0;
      previous_count <= '0;
      res.valid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == sapb_pkg::RegMaxPairs) begin
        max_pairs <= pwdata[5:0];
      end
      unique case (state)
        S_IDLE: if (obj.valid) begin
          in_sph <= obj.is_sphere; in_last <= obj.last_object;
          px <= obj.pos_x; py <= obj.pos_y; pz <= obj.pos_z;
          hx <= obj.half_x; hy <= obj.half_y; hz <= obj.half_z;
          r0 <= obj.axis_row0; r1 <= obj.axis_row1; r2 <= obj.axis_row2;
          in_keep <= load_count < CW'(MAX_OBJECTS);
          slot <= IW'(load_count);
          ext_start <= 1'b1;
          state <= S_EXT;
        end
        S_EXT: if (ext_done) begin
          wb <= '0;
          state <= S_WB;
        end
        S_WB: begin
          // x minimum first, the other five bounds go out as one row
          unique case (wb)
            3'd0:    if (in_keep) object_xmin[slot] <= wb_val;
            3'd1:    wxmax <= wb_val;
            3'd2:    wymin <= wb_val;
            3'd3:    wymax <= wb_val;
            3'd4:    wzmin <= wb_val;
            default: if (in_keep) box_bounds[slot] <= {wb_val, wzmin, wymax, wymin, wxmax};
          endcase
          wb <= wb + 3'd1;
          if (wb == 3'd5) begin
            if (in_keep) load_count <= load_count + 1'b1;
            if (in_last) begin
              n <= in_keep ? load_count + 1'b1 : load_count;
              state <= S_INIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_INIT: begin
          load_count <= '0;
          pairs <= '0;
          i <= '0;
          if (n < CW'(2)) begin
            state <= S_SUM;
          end else begin
            reinit <= (n != previous_count);
            previous_count <= n;
            state <= S_GATHER;
          end
        end
        // gather: order entry, then its x minimum, then into the sort store
        S_GATHER: begin
          if (i == n) begin
            i <= CW'(1);
            state <= S_SORT;
          end else begin
            if (reinit) begin
              sweep_order[i[IW-1:0]] <= i[IW-1:0];
              gord <= i[IW-1:0];
            end else begin
              gord <= sweep_order[i[IW-1:0]];
            end
            state <= S_GREAD;
          end
        end
        S_GREAD: begin
          gx <= object_xmin[gord];
          state <= S_GPUT;
        end
        S_GPUT: begin
          sweep_xmin[i[IW-1:0]] <= gx;
          i <= i + 1'b1;
          state <= S_GATHER;
        end
        // stable insertion sort, one neighbor read and one write per step
        S_SORT: begin
          if (i == n) begin
            a <= '0;
            state <= S_SWA;
          end else begin
            ko <= sweep_order[i[IW-1:0]];
            kx <= sweep_xmin[i[IW-1:0]];
            j <= i;
            state <= S_SREAD;
          end
        end
        S_SREAD: begin
          if (j == '0) begin
            sweep_order[j[IW-1:0]] <= ko;
            sweep_xmin[j[IW-1:0]] <= kx;
            i <= i + 1'b1;
            state <= S_SORT;
          end else begin
            prev_o <= sweep_order[IW'(j - 1'b1)];
            prev_x <= sweep_xmin[IW'(j - 1'b1)];
            state <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (prev_x > kx) begin
            sweep_order[j[IW-1:0]] <= prev_o;
            sweep_xmin[j[IW-1:0]] <= prev_x;
            j <= j - 1'b1;
            state <= S_SREAD;
          end else begin
            sweep_order[j[IW-1:0]] <= ko;
            sweep_xmin[j[IW-1:0]] <= kx;
            i <= i + 1'b1;
            state <= S_SORT;
          end
        end
        // sweep: anchor a against later entries until x separates or the pair limit is hit
        S_SWA: begin
          if (a == n || pairs >= 7'(max_pairs)) begin
            state <= S_SUM;
          end else begin
            oa <= sweep_order[a[IW-1:0]];
            b <= a + 1'b1;
            state <= S_SWABOX;
          end
        end
        S_SWABOX: begin
          abox <= box_bounds[oa];
          state <= S_SWB;
        end
        S_SWB: begin
          if (b == n) begin
            a <= a + 1'b1;
            state <= S_SWA;
          end else begin
            ob <= sweep_order[b[IW-1:0]];
            bx <= sweep_xmin[b[IW-1:0]];
            state <= S_SWBCHK;
          end
        end
        S_SWBCHK: begin
          if (bx > abox.xmax || pairs >= 7'(max_pairs)) begin
            a <= a + 1'b1;
            state <= S_SWA;
          end else begin
            bbox <= box_bounds[ob];
            state <= S_SWBTEST;
          end
        end
        S_SWBTEST: begin
          // touching bounds count as overlap
          if (bbox.ymin > abox.ymax || bbox.ymax < abox.ymin || bbox.zmin > abox.zmax
              || bbox.zmax < abox.zmin) begin
            b <= b + 1'b1;
            state <= S_SWB;
          end else begin
            res.valid <= 1'b1;
            res.pair_valid <= 1'b1;
            res.index_a <= 6'(oa);
            res.index_b <= 6'(ob);
            res.pair_count <= '0;
            res.last <= 1'b0;
            pairs <= pairs + 7'd1;
            b <= b + 1'b1;
            state <= S_EMIT;
          end
        end
        S_EMIT: if (res.ready) begin
          res.valid <= 1'b0;
          state <= S_SWB;
        end
        S_SUM: begin
          if (!res.valid) begin
            res.valid <= 1'b1;
            res.pair_valid <= 1'b0;
            res.index_a <= '0;
            res.index_b <= '0;
            res.pair_count <= pairs[5:0];
            res.last <= 1'b1;
          end else if (res.ready) begin
            res.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // no new object while results are still pending
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !obj.ready) else $error("object taken during result");
  // pair count never exceeds the limit
  a_pair_limit: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.pair_valid) |-> res.pair_count <= max_pairs)
    else $error("pair count over limit");
  // summary always marked last, pair beats never
  a_sum_last: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.last == !res.pair_valid)) else $error("last flag wrong");
endmodule

FILE: dv/sapb_tb_if.sv
`timescale 1ns / 100ps
// shared testbench constants
package sapb_tb_pkg;
  localparam int BeatWaitMax = 4;
endpackage

FILE: dv/sweep_and_prune_broadphase_unit_tb.sv
`timescale 1ns / 100ps
// testbench for the sweep and prune broadphase: directed frames, then random frames
module sweep_and_prune_broadphase_unit_tb;

  typedef struct packed {
    logic       pair_valid;
    logic [5:0] index_a;
    logic [5:0] index_b;
    logic [5:0] pair_count;
    logic       last;
  } pair_beat_t;

  typedef struct {
    logic        is_sphere;
    logic [23:0] pos_x, pos_y, pos_z;
    logic [22:0] half_x, half_y, half_z;
    logic [47:0] axis_row0, axis_row1, axis_row2;
    logic        last_object;
  } object_t;

  localparam int NObj = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [0:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sapb_obj_if obj ();
  sapb_res_if res ();

  sweep_and_prune_broadphase_unit dut (
    .clk(clk), .rst(rst), .obj(obj), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state, mirrors what the block keeps between frames
  logic [5:0]        pair_limit;
  int unsigned       kept_order [NObj];
  sapb_pkg::bound_t  sorted_xmin [NObj];
  sapb_pkg::bound_t  obj_xmin [NObj];
  sapb_pkg::bound_t  obj_bounds [NObj][5];
  int unsigned       prev_frame_count;
  int unsigned       frame_load;

  pair_beat_t pending_pairs[$];
  int errors = 0;

  function automatic logic [16:0] axis_mag(logic [47:0] row, int k);
    logic [15:0] c;
    c = row[16*k +: 16];
    return c[15] ? (17'h10000 - {1'b0, c}) : {1'b0, c};
  endfunction

  function automatic sapb_pkg::bound_t clamp_bound(longint v);
    if (v > longint'(sapb_pkg::BoundMax)) return sapb_pkg::BoundMax;
    if (v < longint'(sapb_pkg::BoundMin)) return sapb_pkg::BoundMin;
    return sapb_pkg::bound_t'(v);
  endfunction

  // box bounds for one arriving object
  task automatic store_object_box(int unsigned idx, object_t o);
    longint p [3];
    longint ext [3];
    logic [22:0] h [3];
    logic [47:0] rows [3];
    longint sum;
    p[0] = longint'($signed(o.pos_x));
    p[1] = longint'($signed(o.pos_y));
    p[2] = longint'($signed(o.pos_z));
    h[0] = o.half_x; h[1] = o.half_y; h[2] = o.half_z;
    rows[0] = o.axis_row0; rows[1] = o.axis_row1; rows[2] = o.axis_row2;
    for (int k = 0; k < 3; k++) begin
      if (o.is_sphere) begin
        ext[k] = longint'(h[0]);
      end else begin
        sum = 0;
        for (int r = 0; r < 3; r++) sum += longint'(axis_mag(rows[r], k)) * longint'(h[r]);
        ext[k] = sum >>> 14;
      end
    end
    obj_xmin[idx] = clamp_bound(p[0] - ext[0]);
    obj_bounds[idx][0] = clamp_bound(p[0] + ext[0]);
    obj_bounds[idx][1] = clamp_bound(p[1] - ext[1]);
    obj_bounds[idx][2] = clamp_bound(p[1] + ext[1]);
    obj_bounds[idx][3] = clamp_bound(p[2] - ext[2]);
    obj_bounds[idx][4] = clamp_bound(p[2] + ext[2]);
  endtask

  // load one object, and on the last one sort, sweep and queue the pair beats and the summary
  task automatic predict_overlaps(object_t o);
    int unsigned n, pairs, ko, oa, ob, j;
    sapb_pkg::bound_t kx;
    pair_beat_t pb;
    pairs = 0;
    if (frame_load < NObj) begin
      store_object_box(frame_load, o);
      frame_load++;
    end
    if (!o.last_object) return;
    n = frame_load;
    frame_load = 0;
    if (n >= 2) begin
      if (n != prev_frame_count) begin
        for (int i = 0; i < n; i++) kept_order[i] = i;
        prev_frame_count = n;
      end
      for (int i = 0; i < n; i++) sorted_xmin[i] = obj_xmin[kept_order[i]];
      // stable insertion sort on x minimum
      for (int i = 1; i < n; i++) begin
        ko = kept_order[i];
        kx = sorted_xmin[i];
        j = i;
        while (j > 0 && sorted_xmin[j-1] > kx) begin
          kept_order[j] = kept_order[j-1];
          sorted_xmin[j] = sorted_xmin[j-1];
          j--;
        end
        kept_order[j] = ko;
        sorted_xmin[j] = kx;
      end
      for (int a = 0; a < n && pairs < pair_limit; a++) begin
        oa = kept_order[a];
        for (int b = a + 1; b < n; b++) begin
          if (sorted_xmin[b] > obj_bounds[oa][0]) break;
          if (pairs >= pair_limit) break;
          ob = kept_order[b];
          if (obj_bounds[ob][1] > obj_bounds[oa][2] || obj_bounds[ob][2] < obj_bounds[oa][1])
            continue;
          if (obj_bounds[ob][3] > obj_bounds[oa][4] || obj_bounds[ob][4] < obj_bounds[oa][3])
            continue;
          pb = '{1'b1, 6'(oa), 6'(ob), 6'd0, 1'b0};
          pending_pairs.push_back(pb);
          pairs++;
        end
      end
    end
    pb = '{1'b0, 6'd0, 6'd0, 6'(pairs), 1'b1};
    pending_pairs.push_back(pb);
  endtask

  // result sink: a random wait ahead of every beat, then the checker
  initial begin
    pair_beat_t got, want;
    int wait_cycles;
    res.ready = 1'b0;
    forever begin
      wait_cycles = $urandom_range(0, sapb_tb_pkg::BeatWaitMax);
      @(negedge clk);
      res.ready = 1'b0;
      repeat (wait_cycles) @(negedge clk);
      res.ready = 1'b1;
      do @(posedge clk); while (rst || !res.valid);
      got = '{res.pair_valid, res.index_a, res.index_b, res.pair_count, res.last};
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual %p", $time, got);
        errors++;
      end else begin
        want = pending_pairs.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  // apb write of one register, only while idle
  task automatic write_pair_limit(logic [5:0] v);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = sapb_pkg::RegMaxPairs; pwdata = 32'(v);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    pair_limit = v;
  endtask

  task automatic drain_results();
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // one object beat, with a random gap ahead of it
  task automatic send_object(object_t o);
    int gap;
    gap = $urandom_range(0, sapb_tb_pkg::BeatWaitMax);
    @(negedge clk);
    repeat (gap) @(negedge clk);
    obj.valid = 1'b1;
    obj.is_sphere = o.is_sphere;
    obj.pos_x = o.pos_x; obj.pos_y = o.pos_y; obj.pos_z = o.pos_z;
    obj.half_x = o.half_x; obj.half_y = o.half_y; obj.half_z = o.half_z;
    obj.axis_row0 = o.axis_row0; obj.axis_row1 = o.axis_row1; obj.axis_row2 = o.axis_row2;
    obj.last_object = o.last_object;
    do @(posedge clk); while (!obj.ready);
    predict_overlaps(o);
    @(negedge clk);
    obj.valid = 1'b0;
  endtask

  function automatic logic [47:0] pack_axis(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  // clustered objects so that overlaps are common
  function automatic object_t random_object(logic fin, int spread);
    object_t o;
    o.is_sphere = 1'($urandom_range(0, 1));
    o.pos_x = 24'($signed($urandom_range(0, 2 * spread)) - spread);
    o.pos_y = 24'($signed($urandom_range(0, 2 * spread)) - spread);
    o.pos_z = 24'($signed($urandom_range(0, 2 * spread)) - spread);
    o.half_x = 23'($urandom_range(0, spread));
    o.half_y = 23'($urandom_range(0, spread));
    o.half_z = 23'($urandom_range(0, spread));
    o.axis_row0 = 48'({$urandom(), $urandom()});
    o.axis_row1 = 48'({$urandom(), $urandom()});
    o.axis_row2 = 48'({$urandom(), $urandom()});
    if ($urandom_range(0, 3) == 0) begin
      o.axis_row0 = pack_axis(16384, 0, 0);
      o.axis_row1 = pack_axis(0, 16384, 0);
      o.axis_row2 = pack_axis(0, 0, 16384);
    end
    o.last_object = fin;
    return o;
  endfunction

  task automatic send_frame(int n, int spread);
    for (int i = 0; i < n; i++) send_object(random_object(i == n - 1, spread));
  endtask

  // extreme fields: full range positions, halves and axis magnitudes
  task automatic test_field_extremes();
    object_t o;
    o = random_object(1'b0, 1000);
    o.is_sphere = 1'b0;
    o.pos_x = 24'h7FFFFF; o.pos_y = 24'h800000; o.pos_z = 24'h7FFFFF;
    o.half_x = 23'h7FFFFF; o.half_y = 23'h7FFFFF; o.half_z = 23'h7FFFFF;
    o.axis_row0 = {3{16'h8000}}; o.axis_row1 = {3{16'h7FFF}}; o.axis_row2 = {3{16'hFFFF}};
    send_object(o);
    o.pos_x = 24'h800000; o.pos_y = 24'h7FFFFF; o.pos_z = 24'h800000;
    o.axis_row0 = '0; o.axis_row1 = {3{16'h8001}}; o.axis_row2 = '1;
    send_object(o);
    o.is_sphere = 1'b1; o.pos_x = 24'd0; o.pos_y = 24'd0; o.pos_z = 24'd0; o.half_x = 23'd0;
    o.last_object = 1'b1;
    send_object(o);
  endtask

  // touching boxes: equal bounds must count as overlap
  task automatic test_touching_boxes();
    object_t o;
    o = random_object(1'b0, 10);
    o.is_sphere = 1'b1; o.pos_x = 24'd0; o.pos_y = 24'd0; o.pos_z = 24'd0;
    o.half_x = 23'd256;
    send_object(o);
    o.pos_x = 24'd512; o.pos_y = 24'd512; o.pos_z = 24'(-512);
    send_object(o);
    o.pos_x = 24'd1025; o.pos_y = 24'd0; o.pos_z = 24'd0; o.last_object = 1'b1;
    send_object(o);
  endtask

  // lone object and two frames of exactly two
  task automatic test_short_frames();
    send_object(random_object(1'b1, 100));
    send_frame(2, 100);
    send_frame(2, 100);
  endtask

  // too many objects, dropped tail still closes the frame
  task automatic test_overflow_frame();
    send_frame(NObj + 3, 4000);
  endtask

  // pair limit extremes: zero, one and the reset value
  task automatic test_pair_limit();
    drain_results();
    write_pair_limit(6'd0);
    send_frame(6, 50);
    drain_results();
    write_pair_limit(6'd1);
    send_frame(6, 50);
    drain_results();
    write_pair_limit(6'd63);
  endtask

  // random frames, the kept order persists when counts repeat
  task automatic test_random_frames();
    int sent, n;
    sent = 0;
    while (sent < 100) begin
      n = ($urandom_range(0, 3) == 0) ? 5 : $urandom_range(1, 12);
      send_frame(n, $urandom_range(0, 1) ? 300 : 3000);
      sent += n;
      if ($urandom_range(0, 4) == 0) begin
        drain_results();
        write_pair_limit(6'($urandom_range(0, 63)));
      end
    end
  endtask

  initial begin
    obj.valid = 1'b0; obj.is_sphere = 1'b0; obj.pos_x = '0; obj.pos_y = '0; obj.pos_z = '0;
    obj.half_x = '0; obj.half_y = '0; obj.half_z = '0;
    obj.axis_row0 = '0; obj.axis_row1 = '0; obj.axis_row2 = '0; obj.last_object = 1'b0;
    pair_limit = 6'(sapb_pkg::MaxPairsReset);
    for (int i = 0; i < NObj; i++) kept_order[i] = i;
    prev_frame_count = 0;
    frame_load = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_pair_limit(6'd63);
    test_field_extremes();
    test_touching_boxes();
    test_short_frames();
    test_overflow_frame();
    test_pair_limit();
    test_random_frames();
    drain_results();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule
